### hdl/schm_pkg.sv
// Shared types and constants for the sensor channel health monitor.
`timescale 1ns / 1ps
package schm_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_DATA_W = 8;

	localparam logic [2:0]         FAIL_LIMIT     = 3'd5;
	localparam logic [9:0]         SAME_LIMIT     = 10'd600;
	localparam logic signed [11:0] AIR_FAIL_VALUE = 12'sd1260;
	localparam logic signed [11:0] DISCONNECT_RAW = -12'sd2032;
	localparam logic [7:0]         CAL_KEY_RESET  = 8'd170;
	localparam logic [3:0]         AIR_CH_OFFSET  = 4'd2;

	typedef enum logic {
		CFG_AIR_PRESENT = 1'b0,
		CFG_CAL_KEY     = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_THERMO = 1'b0,
		CMD_AIR    = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              cmd;
		logic [2:0]        sensor_number;
		logic              read_failed;
		logic signed [11:0] raw_temp;
		logic [7:0]        alarm_high;
		logic signed [7:0] alarm_low;
		logic signed [10:0] air_temp_tenths;
		logic [9:0]        air_humidity_tenths;
	} item_t;

	typedef struct packed {
		logic [2:0]         channel;
		logic signed [11:0] value_tenths;
		logic [2:0]         error_count;
		logic               frozen;
		logic               error_first;
		logic               error_second;
		logic               last;
	} result_t;

endpackage

### hdl/sensor_channel_health_monitor.sv
// Top level: per-channel sensor value store with disconnect and freeze tracking.
//
//  channel   signals                         beat content
//  --------  ------------------------------  ---------------------------------------
//  input     s_axis_tvalid/tready/tdata/tuser one sensor reading, tuser = cmd
//  output    m_axis_tvalid/tready/tdata/tlast one channel update, tlast on final beat
//  config    cfg_valid/ready/index/data       register write, always ready
//
//  Thermometer reading: one input beat per cycle while the output is not stalled, one output beat each if in range.
//  Air-sensor reading: two output beats when an air sensor is configured, so it holds the output register for both.
//  An input beat passes the input register, then one read-modify-write of the
//  channel state into the result register, before the first output beat.
//  Reset clears all channel state and flags and sets the calibration key to 170.
//  Output stalls back up through the result register into the input register.
`timescale 1ns / 1ps
module sensor_channel_health_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// sensor_number, read_failed, raw_temp, alarm_high, alarm_low,
	// air_temp_tenths, air_humidity_tenths, zero pad
	input  logic [schm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// cmd
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// channel, value_tenths, error_count, frozen, error_first, error_second, zero pad
	output logic [schm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [schm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import schm_pkg::*;

	logic               air_present_q;
	logic [7:0]         cal_key_q;

	logic signed [11:0] value_q [CHANNELS];
	logic [2:0]         fail_q  [CHANNELS];
	logic [9:0]         same_q  [CHANNELS];
	logic signed [11:0] prev_q  [CHANNELS];
	logic               flag_first_q;
	logic               flag_second_q;

	item_t              item_s1;
	logic               item_valid_s1;

	result_t            out_q;
	result_t            pend_q;
	logic               out_valid_q;
	logic               pend_valid_q;

	logic               advance;
	logic               out_take;
	logic               has_result;
	logic               is_air;

	logic [3:0]         ch_sum;
	logic               ch_in_range;
	logic [CH_W-1:0]    ch_idx;
	logic [2:0]         fail_old;
	logic               fail_sat;
	logic [2:0]         fail_new;
	logic signed [14:0] n5;
	logic               n_neg;
	logic [13:0]        n_mag;
	logic [10:0]        q_mag;
	logic signed [11:0] tenths;
	logic signed [11:0] calibrated;
	logic signed [11:0] value_new;
	logic signed [11:0] seen;
	logic               same_hit;
	logic               same_sat;
	logic [9:0]         same_new;
	logic               frozen;
	logic               flag_old;
	logic               flag_new;
	logic               flag_first_new;
	logic               flag_second_new;

	logic               air_sat;
	logic [2:0]         air_fail_new;
	logic signed [11:0] air_v0;
	logic signed [11:0] air_v1;

	result_t            res0;
	result_t            res1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_present_q <= 1'b0;
			cal_key_q     <= CAL_KEY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_AIR_PRESENT: air_present_q <= cfg_data[0];
				CFG_CAL_KEY:     cal_key_q     <= cfg_data[7:0];
				default:         air_present_q <= air_present_q;
			endcase
		end
	end

	// Input register
	assign out_take      = out_valid_q && m_axis_tready;
	assign advance       = item_valid_s1 && (!out_valid_q || (m_axis_tready && !pend_valid_q));
	assign s_axis_tready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			item_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.cmd                 <= s_axis_tuser;
			item_s1.sensor_number       <= s_axis_tdata[2:0];
			item_s1.read_failed         <= s_axis_tdata[3];
			item_s1.raw_temp            <= s_axis_tdata[15:4];
			item_s1.alarm_high          <= s_axis_tdata[23:16];
			item_s1.alarm_low           <= s_axis_tdata[31:24];
			item_s1.air_temp_tenths     <= s_axis_tdata[42:32];
			item_s1.air_humidity_tenths <= s_axis_tdata[52:43];
		end
	end

	// Channel update
	always_comb begin
		is_air      = (cmd_t'(item_s1.cmd) == CMD_AIR);
		ch_sum      = {1'b0, item_s1.sensor_number} + (air_present_q ? AIR_CH_OFFSET : 4'd0);
		ch_in_range = ({1'b0, ch_sum} < 5'(CHANNELS));
		ch_idx      = ch_sum[CH_W-1:0];
		has_result  = is_air ? air_present_q : ch_in_range;

		fail_old = fail_q[ch_idx];
		fail_sat = (fail_old >= FAIL_LIMIT);
		fail_new = item_s1.read_failed ? (fail_sat ? FAIL_LIMIT : fail_old + 3'd1) : 3'd0;

		n5    = (15'(item_s1.raw_temp) <<< 2) + 15'(item_s1.raw_temp);
		n_neg = n5[14];
		n_mag = n_neg ? 14'(-n5) : n5[13:0];
		q_mag = 11'((n_mag + 14'd4) >> 3);
		tenths = n_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
		calibrated = tenths + ((item_s1.alarm_high == cal_key_q) ?
			12'(item_s1.alarm_low) : 12'sd0);
		value_new = item_s1.read_failed ? value_q[ch_idx] : calibrated;

		seen     = item_s1.read_failed ? DISCONNECT_RAW : item_s1.raw_temp;
		same_hit = (seen == prev_q[ch_idx]);
		same_sat = (same_q[ch_idx] >= SAME_LIMIT);
		same_new = same_hit ? (same_sat ? SAME_LIMIT : same_q[ch_idx] + 10'd1) : 10'd0;
		frozen   = same_hit && same_sat;

		flag_old = (ch_sum == 4'd0) ? flag_first_q : flag_second_q;
		flag_new = item_s1.read_failed ? (fail_sat || flag_old) : 1'b0;
		flag_new = flag_new || frozen;
		flag_first_new  = flag_first_q;
		flag_second_new = flag_second_q;
		if (!is_air && ch_sum == 4'd0) begin
			flag_first_new = flag_new;
		end
		if (!is_air && ch_sum == 4'd1) begin
			flag_second_new = flag_new;
		end

		air_sat      = (fail_q[0] >= FAIL_LIMIT);
		air_fail_new = item_s1.read_failed ? (air_sat ? FAIL_LIMIT : fail_q[0] + 3'd1) : 3'd0;
		if (item_s1.read_failed) begin
			air_v0 = air_sat ? AIR_FAIL_VALUE : value_q[0];
			air_v1 = air_sat ? AIR_FAIL_VALUE : value_q[1];
		end else begin
			air_v0 = 12'(item_s1.air_temp_tenths);
			air_v1 = $signed({2'b00, item_s1.air_humidity_tenths});
		end

		res0.error_first  = flag_first_new;
		res0.error_second = flag_second_new;
		res1.error_first  = flag_first_new;
		res1.error_second = flag_second_new;
		if (is_air) begin
			res0.channel      = 3'd0;
			res0.value_tenths = air_v0;
			res0.error_count  = air_fail_new;
			res0.frozen       = 1'b0;
			res0.last         = 1'b0;
		end else begin
			res0.channel      = ch_sum[2:0];
			res0.value_tenths = value_new;
			res0.error_count  = fail_new;
			res0.frozen       = frozen;
			res0.last         = 1'b1;
		end
		res1.channel      = 3'd1;
		res1.value_tenths = air_v1;
		res1.error_count  = fail_q[1];
		res1.frozen       = 1'b0;
		res1.last         = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				value_q[k] <= '0;
				fail_q[k]  <= '0;
				same_q[k]  <= '0;
				prev_q[k]  <= '0;
			end
			flag_first_q  <= 1'b0;
			flag_second_q <= 1'b0;
		end else if (advance && has_result) begin
			flag_first_q  <= flag_first_new;
			flag_second_q <= flag_second_new;
			if (is_air) begin
				fail_q[0]  <= air_fail_new;
				value_q[0] <= air_v0;
				value_q[1] <= air_v1;
			end else begin
				fail_q[ch_idx]  <= fail_new;
				value_q[ch_idx] <= value_new;
				same_q[ch_idx]  <= same_new;
				prev_q[ch_idx]  <= seen;
			end
		end
	end

	// Result register with a second slot for the channel 1 beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= is_air;
		end else if (out_take) begin
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_q  <= res0;
			pend_q <= res1;
		end else if (out_take && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tdata  = {3'b000, out_q.error_second, out_q.error_first, out_q.frozen,
		out_q.error_count, out_q.value_tenths, out_q.channel};

`ifndef SYNTHESIS
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("second beat held without a first beat");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (!out_q.last && pend_q.last && pend_q.channel == 3'd1))
		else $error("air beat pair out of order");

	a_nonlast_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last) |-> pend_valid_q)
		else $error("non-final beat without its follower");

	a_fail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q[0] <= FAIL_LIMIT && same_q[0] <= SAME_LIMIT)
		else $error("channel 0 counter past its limit");

	a_air_zero_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has_result && is_air) |=> (out_q.channel == 3'd0 && !out_q.frozen))
		else $error("air result not on channel 0");
`endif

endmodule
